// File: rtl/core/sexpr_lexer_top_assert.svh
// Assertion macros for the lexer checker.
// Each macro clocks on aclk; the first two are disabled while aresetn is low.
`ifndef SEXPR_LEXER_TOP_ASSERT_SVH
`define SEXPR_LEXER_TOP_ASSERT_SVH

// Same-cycle implication
`define SXL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sexpr lexer check failed");

// Next-cycle implication
`define SXL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sexpr lexer check failed");

// Next-cycle implication that also runs through reset
`define SXL_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("sexpr lexer check failed");

`endif

// File: rtl/core/sxl_pkg.sv
package sxl_pkg;

    localparam int CHAR_W    = 8;
    localparam int LINE_W    = 16;
    localparam int COL_W     = 12;
    localparam int LEN_W     = 8;
    localparam int INT_W     = 64;
    localparam int DIGIT_W   = 4;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 144;
    localparam int M_TUSER_W  = 16;
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LEN  = 2'd0;
    localparam logic [LEN_W-1:0]      MAX_LEN_RESET = 8'd64;

    // Largest magnitude that may still take another decimal digit
    localparam logic [INT_W-1:0] MAG_LIMIT = 64'd922337203685477580;

    // Characters with a role of their own
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;

    typedef enum logic [3:0] {
        ST_WS      = 4'd0,
        ST_COMMENT = 4'd1,
        ST_INT     = 4'd2,
        ST_STRING  = 4'd3,
        ST_SYMBOL  = 4'd4,
        ST_OPEN    = 4'd5,
        ST_CLOSE   = 4'd6,
        ST_QUOTE   = 4'd7,
        ST_DOT     = 4'd8
    } lex_state_t;

    typedef enum logic [2:0] {
        TK_INT    = 3'd0,
        TK_STRING = 3'd1,
        TK_SYMBOL = 3'd2,
        TK_OPEN   = 3'd3,
        TK_CLOSE  = 3'd4,
        TK_QUOTE  = 3'd5
    } tok_kind_t;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_INVALID_CHAR = 4'd1,
        ERR_TOO_LONG     = 4'd2,
        ERR_LEADING_ZERO = 4'd3,
        ERR_INT_LARGE    = 4'd4,
        ERR_INT_INVALID  = 4'd5,
        ERR_BAD_ESCAPE   = 4'd6,
        ERR_UNTERMINATED = 4'd7,
        ERR_CLOSE_PAREN  = 4'd8
    } err_code_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_input;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  end_column;
    } in_item_t;

    typedef struct packed {
        logic               digit;
        logic               name;
        logic               ws;
        logic               print;
        logic               nl;
        logic               squote;
        logic               dquote;
        logic               lparen;
        logic               rparen;
        logic               semi;
        logic               dot;
        logic               bslash;
        logic [DIGIT_W-1:0] digit_val;
    } char_class_t;

    typedef struct packed {
        logic              token_valid;
        tok_kind_t         token_kind;
        logic [LINE_W-1:0] token_line;
        logic [COL_W-1:0]  token_col;
        logic [COL_W-1:0]  token_end_col;
        logic [INT_W-1:0]  num_value;
        logic              dot_after;
        logic              text_valid;
        logic [CHAR_W-1:0] text_char;
        err_code_t         err_kind;
        logic [COL_W-1:0]  error_col;
        logic [COL_W-1:0]  error_end_col;
    } result_t;

    // Escape letter to control code; bit 8 flags a known escape
    function automatic logic [CHAR_W:0] escape_map(input logic [CHAR_W-1:0] c);
        logic [CHAR_W:0] r;
        case (c)
            8'h6E:     r = {1'b1, 8'h0A};  // n
            8'h74:     r = {1'b1, 8'h09};  // t
            8'h72:     r = {1'b1, 8'h0D};  // r
            8'h61:     r = {1'b1, 8'h07};  // a
            8'h62:     r = {1'b1, 8'h08};  // b
            8'h66:     r = {1'b1, 8'h0C};  // f
            8'h76:     r = {1'b1, 8'h0B};  // v
            8'h30:     r = {1'b1, 8'h00};  // 0
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            CH_SQUOTE: r = {1'b1, CH_SQUOTE};
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/sxl_class.sv
module sxl_class (
    input  logic [sxl_pkg::CHAR_W-1:0] char_code,
    input  logic                       end_of_input,
    output sxl_pkg::char_class_t       cls
);
    import sxl_pkg::*;

    logic is_ch;

    // Decode one byte; the end marker matches nothing but whitespace
    always_comb begin
        is_ch         = !end_of_input;
        cls           = '0;
        cls.digit     = is_ch && (char_code inside {[8'h30:8'h39]});
        // letters, digits and ~!@#$%^&*_+-=/<>?
        cls.name      = is_ch && (char_code inside {[8'h30:8'h39], [8'h41:8'h5A],
                                                    [8'h61:8'h7A], 8'h7E, 8'h21, 8'h40,
                                                    8'h23, 8'h24, 8'h25, 8'h5E, 8'h26,
                                                    8'h2A, 8'h5F, 8'h2B, 8'h2D, 8'h3D,
                                                    8'h2F, 8'h3C, 8'h3E, 8'h3F});
        cls.ws        = end_of_input ||
                        (char_code inside {CH_SPACE, [CH_TAB:CH_CR], CH_COMMA});
        cls.print     = is_ch && (char_code inside {[CH_SPACE:CH_TILDE]});
        cls.nl        = is_ch && (char_code == CH_CR || char_code == CH_LF);
        cls.squote    = is_ch && (char_code == CH_SQUOTE);
        cls.dquote    = is_ch && (char_code == CH_DQUOTE);
        cls.lparen    = is_ch && (char_code == CH_LPAREN);
        cls.rparen    = is_ch && (char_code == CH_RPAREN);
        cls.semi      = is_ch && (char_code == CH_SEMI);
        cls.dot       = is_ch && (char_code == CH_DOT);
        cls.bslash    = is_ch && (char_code == CH_BSLASH);
        cls.digit_val = char_code[DIGIT_W-1:0];
    end

endmodule

// File: rtl/core/sxl_int.sv
module sxl_int (
    input  logic [sxl_pkg::INT_W-1:0]   mag,
    input  logic                        sign,
    input  logic [sxl_pkg::DIGIT_W-1:0] digit,
    output logic [sxl_pkg::INT_W-1:0]   mag_next,
    output logic                        overflow,
    output logic [sxl_pkg::INT_W-1:0]   value
);
    import sxl_pkg::*;

    logic [DIGIT_W-1:0] top_digit;

    // Shift-add times ten plus the new digit
    assign mag_next  = (mag << 3) + (mag << 1) + {{(INT_W-DIGIT_W){1'b0}}, digit};

    // Negative side reaches one further
    assign top_digit = sign ? 4'd8 : 4'd7;
    assign overflow  = (mag > MAG_LIMIT) || (mag == MAG_LIMIT && digit > top_digit);

    // Two's complement view of sign and magnitude
    assign value     = sign ? (~mag + {{(INT_W-1){1'b0}}, 1'b1}) : mag;

endmodule

// File: rtl/core/sxl_step.sv
module sxl_step (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      fire,
    input  sxl_pkg::in_item_t         item,
    input  logic [sxl_pkg::LEN_W-1:0] max_len,
    output sxl_pkg::result_t          res
);
    import sxl_pkg::*;

    lex_state_t         state_reg, state_next;
    logic               esc_reg, esc_next;
    logic               closed_reg, closed_next;
    logic [INT_W-1:0]   mag_reg, mag_next;
    logic               sign_reg, sign_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [CHAR_W-1:0]  first_reg, first_next;
    logic [LINE_W-1:0]  sline_reg, sline_next;
    logic [COL_W-1:0]   scol_reg, scol_next;
    logic [COL_W-1:0]   lend_reg, lend_next;

    char_class_t        cls;
    logic [INT_W-1:0]   mag_acc;
    logic               acc_ovf;
    logic [INT_W-1:0]   int_val;
    logic [CHAR_W:0]    esc_map;

    // start-of-item decision
    logic               si_go, si_int, si_app, si_err;
    lex_state_t         si_st;
    err_code_t          si_code;
    // delimiter decision
    logic               dl_hit;
    lex_state_t         dl_st;

    logic               use_si, go_en, int_start, app_en, rep_en, rep_rst;
    lex_state_t         go_st;
    logic [CHAR_W-1:0]  app_ch;
    err_code_t          rep_code;
    logic [COL_W-1:0]   rep_col;
    logic [LEN_W-1:0]   len_base;
    logic [COL_W-1:0]   scol_base;

    sxl_class u_class (
        .char_code    (item.char_code),
        .end_of_input (item.end_of_input),
        .cls          (cls)
    );

    sxl_int u_int (
        .mag      (mag_reg),
        .sign     (sign_reg),
        .digit    (cls.digit_val),
        .mag_next (mag_acc),
        .overflow (acc_ovf),
        .value    (int_val)
    );

    assign esc_map = escape_map(item.char_code);

    // Decide how a new item begins; after a dot only token starts are legal
    always_comb begin
        si_go   = 1'b0;
        si_int  = 1'b0;
        si_app  = 1'b0;
        si_err  = 1'b0;
        si_st   = ST_WS;
        si_code = ERR_INVALID_CHAR;
        if (cls.squote) begin
            si_go = 1'b1;
            si_st = ST_QUOTE;
        end else if (cls.digit) begin
            si_go  = 1'b1;
            si_st  = ST_INT;
            si_int = 1'b1;
        end else if (cls.name) begin
            si_go  = 1'b1;
            si_st  = ST_SYMBOL;
            si_app = 1'b1;
        end else if (cls.dquote) begin
            si_go = 1'b1;
            si_st = ST_STRING;
        end else if (cls.lparen) begin
            si_go = 1'b1;
            si_st = ST_OPEN;
        end else if (state_reg == ST_DOT) begin
            si_err  = 1'b1;
            si_code = cls.rparen ? ERR_CLOSE_PAREN : ERR_INVALID_CHAR;
        end else if (cls.ws) begin
            si_go = 1'b1;
            si_st = ST_WS;
        end else if (cls.rparen) begin
            si_go = 1'b1;
            si_st = ST_CLOSE;
        end else if (cls.semi) begin
            si_go = 1'b1;
            si_st = ST_COMMENT;
        end else begin
            si_err = 1'b1;
        end
    end

    // Characters that close an integer or symbol
    always_comb begin
        dl_hit = 1'b1;
        dl_st  = ST_WS;
        if (cls.dot) begin
            dl_st = ST_DOT;
        end else if (cls.ws) begin
            dl_st = ST_WS;
        end else if (cls.lparen) begin
            dl_st = ST_OPEN;
        end else if (cls.rparen) begin
            dl_st = ST_CLOSE;
        end else if (cls.semi) begin
            dl_st = ST_COMMENT;
        end else begin
            dl_hit = 1'b0;
        end
    end

    // Next state and result for the item in the input register
    always_comb begin
        use_si      = 1'b0;
        go_en       = 1'b0;
        go_st       = ST_WS;
        int_start   = 1'b0;
        app_en      = 1'b0;
        app_ch      = item.char_code;
        rep_en      = 1'b0;
        rep_rst     = 1'b0;
        rep_code    = ERR_NONE;
        rep_col     = item.column;
        len_base    = len_reg;
        scol_base   = scol_reg;
        res         = '0;

        state_next  = state_reg;
        esc_next    = esc_reg;
        closed_next = closed_reg;
        mag_next    = mag_reg;
        sign_next   = sign_reg;
        len_next    = len_reg;
        first_next  = first_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        lend_next   = lend_reg;

        case (state_reg)
            ST_CLOSE: begin
                if (cls.dot) begin
                    go_en = 1'b1;
                    go_st = ST_DOT;
                end else begin
                    use_si = 1'b1;
                end
            end
            ST_INT: begin
                if (cls.digit) begin
                    if (mag_reg == '0) begin
                        rep_en   = 1'b1;
                        rep_rst  = 1'b1;
                        rep_code = ERR_LEADING_ZERO;
                        rep_col  = scol_reg;
                    end else begin
                        lend_next = item.end_column;
                        if (acc_ovf) begin
                            rep_en   = 1'b1;
                            rep_rst  = 1'b1;
                            rep_code = ERR_INT_LARGE;
                            rep_col  = scol_reg;
                        end else begin
                            mag_next = mag_acc;
                        end
                    end
                end else if (dl_hit) begin
                    go_en = 1'b1;
                    go_st = dl_st;
                end else begin
                    rep_en   = 1'b1;
                    rep_rst  = 1'b1;
                    rep_code = ERR_INT_INVALID;
                    rep_col  = scol_reg;
                end
            end
            ST_STRING: begin
                if (closed_reg) begin
                    if (cls.dot) begin
                        go_en = 1'b1;
                        go_st = ST_DOT;
                    end else begin
                        use_si = 1'b1;
                    end
                end else if (esc_reg) begin
                    esc_next = 1'b0;
                    if (esc_map[CHAR_W] && !item.end_of_input) begin
                        app_en = 1'b1;
                        app_ch = esc_map[CHAR_W-1:0];
                    end else begin
                        rep_en   = 1'b1;
                        rep_rst  = 1'b1;
                        rep_code = ERR_BAD_ESCAPE;
                        rep_col  = item.column - {{(COL_W-1){1'b0}}, 1'b1};
                    end
                end else if (cls.bslash) begin
                    esc_next = 1'b1;
                end else if (cls.dquote) begin
                    lend_next   = item.end_column;
                    closed_next = 1'b1;
                end else if (cls.print) begin
                    lend_next = item.end_column;
                    app_en    = 1'b1;
                end else begin
                    rep_en   = 1'b1;
                    rep_rst  = 1'b1;
                    rep_code = cls.nl ? ERR_UNTERMINATED : ERR_INVALID_CHAR;
                end
            end
            ST_SYMBOL: begin
                if (cls.digit && len_reg == {{(LEN_W-1){1'b0}}, 1'b1} &&
                    (first_reg == CH_PLUS || first_reg == CH_MINUS)) begin
                    if (cls.digit_val == '0) begin
                        rep_en   = 1'b1;
                        rep_rst  = 1'b1;
                        rep_code = ERR_LEADING_ZERO;
                        rep_col  = scol_reg;
                    end else begin
                        mag_next   = {{(INT_W-DIGIT_W){1'b0}}, cls.digit_val};
                        sign_next  = (first_reg == CH_MINUS);
                        lend_next  = item.end_column;
                        state_next = ST_INT;
                    end
                end else if (cls.name) begin
                    lend_next = item.end_column;
                    app_en    = 1'b1;
                end else if (dl_hit) begin
                    go_en = 1'b1;
                    go_st = dl_st;
                end else begin
                    rep_en   = 1'b1;
                    rep_rst  = 1'b1;
                    rep_code = ERR_INVALID_CHAR;
                end
            end
            ST_COMMENT: begin
                if (cls.nl) begin
                    go_en = 1'b1;
                    go_st = ST_WS;
                end else if (cls.print) begin
                    go_en = 1'b1;
                    go_st = ST_COMMENT;
                end else begin
                    rep_en   = 1'b1;
                    rep_rst  = 1'b1;
                    rep_code = ERR_INVALID_CHAR;
                end
            end
            default: begin
                use_si = 1'b1;
            end
        endcase

        // Take the start-of-item decision where the state asks for it
        if (use_si) begin
            go_en     = si_go;
            go_st     = si_st;
            int_start = si_int;
            app_en    = si_app;
            if (si_err) begin
                rep_en   = 1'b1;
                rep_rst  = 1'b1;
                rep_code = si_code;
            end
        end

        // Close the current token and open the next one
        if (go_en) begin
            res.token_line    = sline_reg;
            res.token_col     = scol_reg;
            res.token_end_col = lend_reg;
            case (state_reg)
                ST_INT: begin
                    res.token_valid = 1'b1;
                    res.token_kind  = TK_INT;
                    res.num_value   = int_val;
                    res.dot_after   = (go_st == ST_DOT);
                end
                ST_STRING: begin
                    res.token_valid = 1'b1;
                    res.token_kind  = TK_STRING;
                    res.dot_after   = (go_st == ST_DOT);
                end
                ST_SYMBOL: begin
                    res.token_valid = 1'b1;
                    res.token_kind  = TK_SYMBOL;
                    res.dot_after   = (go_st == ST_DOT);
                end
                ST_OPEN: begin
                    res.token_valid = 1'b1;
                    res.token_kind  = TK_OPEN;
                end
                ST_CLOSE: begin
                    res.token_valid = 1'b1;
                    res.token_kind  = TK_CLOSE;
                    res.dot_after   = (go_st == ST_DOT);
                end
                ST_QUOTE: begin
                    res.token_valid = 1'b1;
                    res.token_kind  = TK_QUOTE;
                end
                default: begin
                    res.token_line    = '0;
                    res.token_col     = '0;
                    res.token_end_col = '0;
                end
            endcase
            state_next  = go_st;
            sline_next  = item.line_number;
            scol_next   = item.column;
            lend_next   = item.end_column;
            esc_next    = 1'b0;
            closed_next = 1'b0;
            mag_next    = '0;
            sign_next   = 1'b0;
            len_next    = '0;
            first_next  = '0;
            len_base    = '0;
            scol_base   = item.column;
        end

        // A leading digit seeds the accumulator
        if (int_start) begin
            mag_next = {{(INT_W-DIGIT_W){1'b0}}, cls.digit_val};
        end

        // Append one text character, or flag the token as too long
        if (app_en) begin
            if (len_base >= max_len) begin
                rep_en   = 1'b1;
                rep_code = ERR_TOO_LONG;
                rep_col  = scol_base;
            end else begin
                if (len_base == '0) begin
                    first_next = app_ch;
                end
                len_next       = len_base + {{(LEN_W-1){1'b0}}, 1'b1};
                res.text_valid = 1'b1;
                res.text_char  = app_ch;
            end
        end

        // Drop the token and fall back to whitespace
        if (rep_rst) begin
            state_next  = ST_WS;
            esc_next    = 1'b0;
            closed_next = 1'b0;
            mag_next    = '0;
            sign_next   = 1'b0;
            len_next    = '0;
            first_next  = '0;
        end

        if (rep_en) begin
            res.err_kind      = rep_code;
            res.error_col     = rep_col;
            res.error_end_col = item.end_column;
        end
    end

    // Scanner state advances once per transfer through the step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_WS;
            esc_reg    <= 1'b0;
            closed_reg <= 1'b0;
            mag_reg    <= '0;
            sign_reg   <= 1'b0;
            len_reg    <= '0;
            first_reg  <= '0;
            sline_reg  <= '0;
            scol_reg   <= '0;
            lend_reg   <= '0;
        end else if (fire) begin
            state_reg  <= state_next;
            esc_reg    <= esc_next;
            closed_reg <= closed_next;
            mag_reg    <= mag_next;
            sign_reg   <= sign_next;
            len_reg    <= len_next;
            first_reg  <= first_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            lend_reg   <= lend_next;
        end
    end

endmodule

// File: rtl/core/sexpr_lexer_top.sv
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tdata: one source character, s_tlast: end of input
// m_*       out  m_tvalid/m_tready   m_tdata/m_tuser: one result per character
// APB       in   psel/penable        register 0 at address 0: token text limit
//
// One character per cycle sustained while m_tready is high; m_tvalid rises once the
// character transfer has passed the input register and then the result register.
// The scanner step is a single pass of combinational logic between them.
// Reset (aresetn low, synchronous) empties both registers, puts the scanner in
// whitespace and restores the token text limit to 64.
// A stall on m_tready holds the result; s_tready drops in that same cycle once the
// input register is full too, so at most two characters are held inside.
module sexpr_lexer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // [7:0] char_code, [23:8] line_number, [35:24] column, [47:36] end_column
    input  logic [sxl_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] token_line, [27:16] token_col, [39:28] token_end_col,
    // [103:40] num_value, [104] dot_after, [112:105] text_char,
    // [124:113] error_col, [136:125] error_end_col, rest zero
    output logic [sxl_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] token_valid, [3:1] token_kind, [4] text_valid, [8:5] err_kind, rest zero
    output logic [sxl_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sxl_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sxl_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sxl_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import sxl_pkg::*;

    logic             in_valid_reg, in_valid_next;
    in_item_t         in_item_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg;
    result_t          step_res;
    logic [LEN_W-1:0] max_len_reg, max_len_next;
    logic             advance;
    logic             step_fire;
    logic             cfg_write;

    // Pipeline moves when the result register is free or being drained
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign step_fire = in_valid_reg && advance;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (step_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // Configuration register
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite && pready && (paddr == ADDR_MAX_LEN);
    assign max_len_next = cfg_write ? pwdata[LEN_W-1:0] : max_len_reg;
    assign prdata       = (paddr == ADDR_MAX_LEN) ?
                          {{(APB_DATA_W-LEN_W){1'b0}}, max_len_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            max_len_reg   <= max_len_next;
        end
    end

    // Capture the character on each input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.char_code    <= s_tdata[7:0];
            in_item_reg.end_of_input <= s_tlast;
            in_item_reg.line_number  <= s_tdata[23:8];
            in_item_reg.column       <= s_tdata[35:24];
            in_item_reg.end_column   <= s_tdata[47:36];
        end
    end

    sxl_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (step_fire),
        .item    (in_item_reg),
        .max_len (max_len_reg),
        .res     (step_res)
    );

    // Hold the result until the output transfer
    always_ff @(posedge aclk) begin
        if (step_fire) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0,
                       res_reg.error_end_col,
                       res_reg.error_col,
                       res_reg.text_char,
                       res_reg.dot_after,
                       res_reg.num_value,
                       res_reg.token_end_col,
                       res_reg.token_col,
                       res_reg.token_line};
    assign m_tuser  = {7'd0,
                       res_reg.err_kind,
                       res_reg.text_valid,
                       res_reg.token_kind,
                       res_reg.token_valid};

endmodule

// File: rtl/core/sexpr_lexer_checker.sv
`include "sexpr_lexer_top_assert.svh"

module sexpr_lexer_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [sxl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sxl_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import sxl_pkg::*;

    // Stalled result holds
    `SXL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // Token kinds stay in range and only integers carry a value
    `SXL_ASSERT_NOW(a_kind_value, m_tvalid && m_tuser[0],
                    m_tuser[3:1] <= 3'(TK_QUOTE) &&
                    (m_tuser[3:1] == 3'(TK_INT) || m_tdata[103:40] == 64'd0))

    // No error means no error span
    `SXL_ASSERT_NOW(a_err_span, m_tvalid && m_tuser[8:5] == 4'(ERR_NONE),
                    m_tdata[136:113] == 24'd0)

    // Text byte is zero unless text is streamed
    `SXL_ASSERT_NOW(a_text_zero, m_tvalid && !m_tuser[4], m_tdata[112:105] == 8'd0)

    // Reset empties the result register
    `SXL_ASSERT_NEXT_ALWAYS(a_reset_empty, !aresetn, !m_tvalid)

endmodule

bind sexpr_lexer_top sexpr_lexer_checker u_checker (.*);
